>>> rtl/core/xie_pkg.sv
`timescale 1ns / 1ps

package xie_pkg;

    // Operand kinds
    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_IMM = 2'd1;
    localparam logic [1:0] KIND_MEM = 2'd2;

    // Operation codes
    localparam logic [4:0] FN_MOVQ  = 5'd0;
    localparam logic [4:0] FN_ADDQ  = 5'd1;
    localparam logic [4:0] FN_SUBQ  = 5'd2;
    localparam logic [4:0] FN_CMPQ  = 5'd3;
    localparam logic [4:0] FN_IDIVQ = 5'd4;
    localparam logic [4:0] FN_NEGQ  = 5'd5;
    localparam logic [4:0] FN_IMULQ = 5'd6;
    localparam logic [4:0] FN_PUSHQ = 5'd7;
    localparam logic [4:0] FN_POPQ  = 5'd8;
    localparam logic [4:0] FN_JE    = 5'd9;
    localparam logic [4:0] FN_JNE   = 5'd10;
    localparam logic [4:0] FN_JL    = 5'd11;
    localparam logic [4:0] FN_JG    = 5'd12;
    localparam logic [4:0] FN_JLE   = 5'd13;
    localparam logic [4:0] FN_JGE   = 5'd14;
    localparam logic [4:0] FN_JMP   = 5'd15;
    localparam logic [4:0] FN_CALL  = 5'd16;
    localparam logic [4:0] FN_CQO   = 5'd17;
    localparam logic [4:0] FN_RET   = 5'd18;

    // Opcode bytes
    localparam logic [7:0] OP_REX       = 8'h40;
    localparam logic [7:0] OP_REX_W     = 8'h48;
    localparam logic [7:0] OP_REX_B     = 8'h41;
    localparam logic [7:0] OP_MOV_STORE = 8'h89;
    localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
    localparam logic [7:0] OP_ADD_STORE = 8'h01;
    localparam logic [7:0] OP_ADD_LOAD  = 8'h03;
    localparam logic [7:0] OP_SUB_STORE = 8'h29;
    localparam logic [7:0] OP_SUB_LOAD  = 8'h2B;
    localparam logic [7:0] OP_CMP_STORE = 8'h39;
    localparam logic [7:0] OP_CMP_LOAD  = 8'h3B;
    localparam logic [7:0] OP_MOV_IMM   = 8'hC7;
    localparam logic [7:0] OP_ALU_IMM8  = 8'h83;
    localparam logic [7:0] OP_ALU_IMM32 = 8'h81;
    localparam logic [7:0] OP_GRP3      = 8'hF7;
    localparam logic [7:0] OP_PUSH      = 8'h50;
    localparam logic [7:0] OP_POP       = 8'h58;
    localparam logic [7:0] OP_CQO       = 8'h99;
    localparam logic [7:0] OP_RET       = 8'hC3;

    // ModR/M mod field
    localparam logic [1:0] MOD_D8  = 2'd1;
    localparam logic [1:0] MOD_D32 = 2'd2;
    localparam logic [1:0] MOD_REG = 2'd3;

    // Opcode extensions
    localparam logic [2:0] EXT_ADD  = 3'd0;
    localparam logic [2:0] EXT_SUB  = 3'd5;
    localparam logic [2:0] EXT_CMP  = 3'd7;
    localparam logic [2:0] EXT_NEG  = 3'd3;
    localparam logic [2:0] EXT_IMUL = 3'd5;
    localparam logic [2:0] EXT_IDIV = 3'd7;

    localparam int MAX_BYTES = 11;

    typedef logic [3:0] t_byte_idx;
    typedef logic [7:0] t_code [MAX_BYTES];

    function automatic logic fits8(input logic [31:0] v);
        fits8 = (v[31:7] == '0) || (v[31:7] == '1);
    endfunction

    function automatic logic [7:0] rex_of(input logic [3:0] r, input logic [3:0] b);
        rex_of = OP_REX_W | {5'd0, r[3], 1'b0, b[3]};
    endfunction

    function automatic logic [7:0] modrm_of(input logic [1:0] md, input logic [2:0] r,
                                            input logic [2:0] b);
        modrm_of = {md, r, b};
    endfunction

    function automatic logic [7:0] jump_op(input logic [4:0] fn);
        case (fn)
            FN_JE:   jump_op = 8'h74;
            FN_JNE:  jump_op = 8'h75;
            FN_JL:   jump_op = 8'h7C;
            FN_JG:   jump_op = 8'h7F;
            FN_JLE:  jump_op = 8'h7E;
            FN_JGE:  jump_op = 8'h7D;
            FN_JMP:  jump_op = 8'hEB;
            FN_CALL: jump_op = 8'hE8;
            default: jump_op = 8'h00;
        endcase
    endfunction

endpackage

>>> rtl/core/x86_64_instruction_encoder.sv
`timescale 1ns / 1ps
// Flow: a taken request waits in the input register, then is encoded into the byte buffer,
// which loads only when empty or as its final byte leaves; the buffer drives the output.
// Output: one code byte per cycle while i_stall is low; an instruction is 1 to 11 bytes,
// streamed through the single byte-wide output port.
// Reset: synchronous, active low; clears both stage valids and the byte index.
module x86_64_instruction_encoder
    import xie_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [4:0]         i_func,
    input  logic [1:0]         i_src_kind,
    input  logic [1:0]         i_dest_kind,
    input  logic [3:0]         i_src_reg,
    input  logic [3:0]         i_dest_reg,
    input  logic signed [31:0] i_immediate,
    input  logic signed [31:0] i_displacement,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_code_byte,
    output logic               o_last_byte,
    output logic               o_unsupported
);

    // Input register: one request waiting to be encoded.
    logic        r_in_valid;
    logic [4:0]  r_func;
    logic [1:0]  r_sk;
    logic [1:0]  r_dk;
    logic [3:0]  r_sr;
    logic [3:0]  r_dr;
    logic [31:0] r_imm;
    logic [31:0] r_disp;

    // Byte buffer: the encoded instruction being streamed out.
    logic      r_buf_valid;
    t_code     r_code;
    t_byte_idx r_idx;
    t_byte_idx r_last_idx;
    logic      r_unsup;

    // Encoder outputs
    t_code     n_code;
    t_byte_idx n_last_idx;
    logic      n_unsup;

    logic in_take;
    logic out_take;
    logic out_done;
    logic ld_buf;

    // Encoder working signals
    logic [7:0] hd [3];
    logic [2:0] hlen;
    logic [2:0] dlen;
    logic [2:0] ilen;
    logic       ok;
    logic [1:0] f;
    logic       is_mov;
    logic       short_imm;
    logic       disp8;
    logic [7:0] imm_op;
    logic [7:0] store_op;
    logic [7:0] load_op;
    logic [2:0] ext;
    logic [1:0] mem_mod;
    logic [2:0] mem_dlen;
    logic [2:0] imm_len;
    logic [3:0] off;
    logic [3:0] ioff;
    logic [3:0] tot;

    // The output side reads straight from the buffer; the index holds while stalled,
    // so the payload stays put.
    assign o_valid       = r_buf_valid;
    assign o_code_byte   = r_code[r_idx];
    assign o_last_byte   = (r_idx == r_last_idx);
    assign o_unsupported = r_unsup;

    assign out_take = r_buf_valid && !i_stall;
    assign out_done = out_take && o_last_byte;
    // Refill the buffer when it is empty or its final byte leaves this cycle.
    assign ld_buf   = r_in_valid && (!r_buf_valid || out_done);
    assign o_stall  = r_in_valid && !ld_buf;
    assign in_take  = i_valid && !o_stall;

    // Encode: a head of up to three bytes (REX, opcode, ModR/M), then displacement, then immediate.
    always_comb begin
        f         = r_func[1:0];
        is_mov    = (f == FN_MOVQ[1:0]);
        short_imm = !is_mov && fits8(r_imm);
        disp8     = fits8(r_disp);
        mem_mod   = disp8 ? MOD_D8 : MOD_D32;
        mem_dlen  = disp8 ? 3'd1 : 3'd4;
        imm_len   = short_imm ? 3'd1 : 3'd4;
        imm_op    = is_mov ? OP_MOV_IMM : (short_imm ? OP_ALU_IMM8 : OP_ALU_IMM32);

        case (f)
            FN_MOVQ[1:0]: begin
                store_op = OP_MOV_STORE;
                load_op  = OP_MOV_LOAD;
                ext      = EXT_ADD;
            end
            FN_ADDQ[1:0]: begin
                store_op = OP_ADD_STORE;
                load_op  = OP_ADD_LOAD;
                ext      = EXT_ADD;
            end
            FN_SUBQ[1:0]: begin
                store_op = OP_SUB_STORE;
                load_op  = OP_SUB_LOAD;
                ext      = EXT_SUB;
            end
            default: begin
                store_op = OP_CMP_STORE;
                load_op  = OP_CMP_LOAD;
                ext      = EXT_CMP;
            end
        endcase

        ok    = 1'b1;
        hlen  = 3'd3;
        dlen  = 3'd0;
        ilen  = 3'd0;
        hd[0] = 8'h00;
        hd[1] = 8'h00;
        hd[2] = 8'h00;

        if (r_func <= FN_CMPQ) begin
            if (r_sk == KIND_REG && r_dk == KIND_REG) begin
                hd[0] = rex_of(r_sr, r_dr);
                hd[1] = store_op;
                hd[2] = modrm_of(MOD_REG, r_sr[2:0], r_dr[2:0]);
            end else if (r_sk == KIND_IMM && r_dk == KIND_REG) begin
                hd[0] = rex_of(4'd0, r_dr);
                hd[1] = imm_op;
                hd[2] = modrm_of(MOD_REG, ext, r_dr[2:0]);
                ilen  = imm_len;
            end else if (f == FN_CMPQ[1:0]) begin
                // compare has only the two register-destination forms
                ok = 1'b0;
            end else if (r_sk == KIND_IMM && r_dk == KIND_MEM) begin
                hd[0] = rex_of(4'd0, r_dr);
                hd[1] = imm_op;
                hd[2] = modrm_of(mem_mod, ext, r_dr[2:0]);
                dlen  = mem_dlen;
                ilen  = imm_len;
            end else if (r_sk == KIND_REG && r_dk == KIND_MEM) begin
                hd[0] = rex_of(r_sr, r_dr);
                hd[1] = store_op;
                hd[2] = modrm_of(mem_mod, r_sr[2:0], r_dr[2:0]);
                dlen  = mem_dlen;
            end else if (r_sk == KIND_MEM && r_dk == KIND_REG) begin
                hd[0] = rex_of(r_dr, r_sr);
                hd[1] = load_op;
                hd[2] = modrm_of(mem_mod, r_dr[2:0], r_sr[2:0]);
                dlen  = mem_dlen;
            end else begin
                ok = 1'b0;
            end
        end else if (r_func <= FN_IMULQ) begin
            hd[0] = rex_of(4'd0, r_sr);
            hd[1] = OP_GRP3;
            if (r_func == FN_IDIVQ) begin
                hd[2] = modrm_of(MOD_REG, EXT_IDIV, r_sr[2:0]);
            end else if (r_func == FN_NEGQ) begin
                hd[2] = modrm_of(MOD_REG, EXT_NEG, r_sr[2:0]);
            end else begin
                hd[2] = modrm_of(MOD_REG, EXT_IMUL, r_sr[2:0]);
            end
            ok = (r_sk == KIND_REG);
        end else if (r_func <= FN_POPQ) begin
            ok = (r_sk == KIND_REG);
            if (r_sr[3]) begin
                hd[0] = OP_REX_B;
                hd[1] = ((r_func == FN_PUSHQ) ? OP_PUSH : OP_POP) | {5'd0, r_sr[2:0]};
                hlen  = 3'd2;
            end else begin
                hd[0] = ((r_func == FN_PUSHQ) ? OP_PUSH : OP_POP) | {5'd0, r_sr[2:0]};
                hlen  = 3'd1;
            end
        end else if (r_func <= FN_CALL) begin
            hd[0] = jump_op(r_func);
            hlen  = 3'd1;
        end else if (r_func == FN_CQO) begin
            hd[0] = OP_REX_W;
            hd[1] = OP_CQO;
            hlen  = 3'd2;
        end else if (r_func == FN_RET) begin
            hd[0] = OP_RET;
            hlen  = 3'd1;
        end else begin
            ok = 1'b0;
        end

        // Place each output byte independently: head, then displacement, then immediate.
        off  = 4'd0;
        ioff = 4'd0;
        for (int p = 0; p < MAX_BYTES; p++) begin
            off = 4'(p) - 4'd3;
            ioff = off - {1'b0, dlen};
            if (p < 3) begin
                n_code[p] = hd[p];
            end else if (off < {1'b0, dlen}) begin
                n_code[p] = r_disp[{off[1:0], 3'b000} +: 8];
            end else begin
                n_code[p] = r_imm[{ioff[1:0], 3'b000} +: 8];
            end
        end

        tot = {1'b0, hlen} + {1'b0, dlen} + {1'b0, ilen};
        if (ok) begin
            n_last_idx = tot - 4'd1;
            n_unsup    = 1'b0;
        end else begin
            // one flagged zero byte
            n_code[0]  = 8'h00;
            n_last_idx = 4'd0;
            n_unsup    = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_buf_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (ld_buf) begin
                r_in_valid <= 1'b0;
            end

            if (ld_buf) begin
                r_buf_valid <= 1'b1;
                r_idx       <= '0;
            end else if (out_done) begin
                r_buf_valid <= 1'b0;
            end else if (out_take) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // Payload: capture the request, load the encoded bytes.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func <= i_func;
            r_sk   <= i_src_kind;
            r_dk   <= i_dest_kind;
            r_sr   <= i_src_reg;
            r_dr   <= i_dest_reg;
            r_imm  <= i_immediate;
            r_disp <= i_displacement;
        end
        if (ld_buf) begin
            r_code     <= n_code;
            r_last_idx <= n_last_idx;
            r_unsup    <= n_unsup;
        end
    end

    // A freshly loaded instruction always starts streaming at its first byte.
    a_load_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_buf |=> (r_buf_valid && r_idx == 4'd0))
        else $error("buffer load did not restart the byte index");

    // The byte index never runs past the final byte.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_valid |-> (r_idx <= r_last_idx))
        else $error("byte index beyond final byte");

    // A rejected instruction is a single flagged byte.
    a_unsup_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_unsupported) |-> (o_last_byte && o_code_byte == 8'h00))
        else $error("unsupported instruction not a single zero byte");

    // The input register only waits while the buffer is still streaming.
    a_stall_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_buf_valid && !out_done))
        else $error("input stalled with buffer free");

endmodule
